// ===== rtl/ihbf_pkg.sv =====
`default_nettype none

package ihbf_pkg;

    localparam int LANES      = 4;
    localparam int MAX_COMP   = 4;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_AW     = $clog2(MAX_WIDTH);
    localparam int CNT_W      = 12;
    localparam int DIM_W      = 13;
    localparam int LANE_W     = 8;
    localparam int SUM_W      = 9;
    localparam int PIX_W      = LANES * LANE_W;
    localparam int ROW_W      = LANES * SUM_W;
    localparam int QDEPTH     = 2;
    localparam int QAW        = $clog2(QDEPTH);

    // register map, word index
    localparam logic [1:0] REG_HALVE_MODE  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH = 2'd1;
    localparam logic [1:0] REG_IMAGE_HGT   = 2'd2;
    localparam logic [1:0] REG_COMP_COUNT  = 2'd3;

    localparam logic [1:0] MODE_BOTH  = 2'd0;
    localparam logic [1:0] MODE_HORIZ = 2'd1;
    localparam logic [1:0] MODE_VERT  = 2'd2;

    typedef struct packed {
        logic [1:0]       halve_mode;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [2:0]       comp_count;
    } t_cfg;

    typedef enum logic [1:0] {
        K_STORE = 2'd0,
        K_BOX   = 2'd1,
        K_PAIR  = 2'd2,
        K_VERT  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ROW_AW-1:0] idx;
        logic [ROW_W-1:0]  sum;
        logic              row_end;
        logic              frame_end;
    } t_op;

endpackage

`default_nettype wire

// ===== rtl/image_halve_box_filter_top.sv =====
`default_nettype none

// channel   | dir | handshake                  | payload
// ----------+-----+----------------------------+------------------------------------------
// pixel in  | in  | i_s_tvalid / o_s_tready    | i_s_tdata: c0, c1, c2, c3 (8b each)
// pixel out | out | o_m_tvalid / i_m_tready    | o_m_tdata: c0..c3, tlast row end, tuser frame end
// config    | in  | psel, penable, pwrite      | paddr word index, pwdata / prdata, pready high
//
// one input word per cycle while o_s_tready is high; a result reaches o_m_tvalid from the pixel
// that completes it via front classify -> queue -> row store read -> output reg
// reset clears config to mode 0, 2x2 frame, 4 components and zeroes the raster position;
// the 4096-entry row store is not cleared, odd rows only read what the even row wrote
// a stalled output backs up through the two-entry queue, o_s_tready drops when it is full
// pixels are swallowed without result while the configuration is out of range

module image_halve_box_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [7:0] pixel_c0, [15:8] pixel_c1, [23:16] c2, [31:24] c3
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] out_c0, [15:8] out_c1, [23:16] c2, [31:24] c3
    output logic        o_m_tlast,   // row_end
    output logic [0:0]  o_m_tuser,   // [0] frame_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ihbf_pkg::*;

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [1:0] reg_idx;
    logic       q_full, q_valid, q_push, q_pop;
    t_op        f_op, q_op;
    logic       frame_end;

    // config registers, any write restarts the frame
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.halve_mode <= MODE_BOTH;
            r_cfg.width      <= DIM_W'(2);
            r_cfg.height     <= DIM_W'(2);
            r_cfg.comp_count <= 3'd4;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_HALVE_MODE:  r_cfg.halve_mode <= pwdata[1:0];
                REG_IMAGE_WIDTH: r_cfg.width      <= pwdata[DIM_W-1:0];
                REG_IMAGE_HGT:   r_cfg.height     <= pwdata[DIM_W-1:0];
                REG_COMP_COUNT:  r_cfg.comp_count <= pwdata[2:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HALVE_MODE:  prdata = 32'(r_cfg.halve_mode);
            REG_IMAGE_WIDTH: prdata = 32'(r_cfg.width);
            REG_IMAGE_HGT:   prdata = 32'(r_cfg.height);
            REG_COMP_COUNT:  prdata = 32'(r_cfg.comp_count);
        endcase
    end

    // front: raster tracking, held pixel, op classification
    ihbf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_data    (i_s_tdata),
        .i_cfg     (r_cfg),
        .i_restart (cfg_wr),
        .i_q_full  (q_full),
        .o_ready   (o_s_tready),
        .o_push    (q_push),
        .o_op      (f_op)
    );

    // decouples the accept side from the row store and output stall
    ihbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (f_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    // back: row store access, averaging, output register
    ihbf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_op      (q_op),
        .o_pop       (q_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata),
        .o_row_end   (o_m_tlast),
        .o_frame_end (frame_end)
    );

    assign o_m_tuser = frame_end;

endmodule

`default_nettype wire

// ===== rtl/ihbf_front.sv =====
`default_nettype none

module ihbf_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [ihbf_pkg::PIX_W-1:0] i_data,
    input  ihbf_pkg::t_cfg             i_cfg,
    input  logic                       i_restart,
    input  logic                       i_q_full,
    output logic                       o_ready,
    output logic                       o_push,
    output ihbf_pkg::t_op              o_op
);
    import ihbf_pkg::*;

    logic [CNT_W-1:0]  r_col, n_col;
    logic [CNT_W-1:0]  r_row, n_row;
    logic [PIX_W-1:0]  r_held, n_held;

    logic              cfg_ok;
    logic              accept;
    logic              emit;
    logic [PIX_W-1:0]  pix;
    logic [ROW_W-1:0]  pair_sum;
    logic [ROW_W-1:0]  pix_wide;
    logic [DIM_W-1:0]  col13, row13;
    logic [DIM_W-1:0]  w_even, h_even;
    logic [CNT_W-1:0]  col_half_nx, row_half_nx;
    logic              half_rend, half_fend;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    // configuration sanity, pixels are swallowed when it fails
    always_comb begin
        cfg_ok = 1'b1;
        if (i_cfg.halve_mode > MODE_VERT || i_cfg.comp_count == 3'd0) cfg_ok = 1'b0;
        if (i_cfg.width == '0 || i_cfg.width > DIM_W'(MAX_WIDTH)) cfg_ok = 1'b0;
        if (i_cfg.height == '0 || i_cfg.height > DIM_W'(MAX_HEIGHT)) cfg_ok = 1'b0;
        if (i_cfg.halve_mode != MODE_VERT && i_cfg.width < DIM_W'(2)) cfg_ok = 1'b0;
        if (i_cfg.halve_mode != MODE_HORIZ && i_cfg.height < DIM_W'(2)) cfg_ok = 1'b0;
    end

    // unused lanes forced to zero up front
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (k < MAX_COMP && i_cfg.comp_count > 3'(k)) begin
                pix[k*LANE_W +: LANE_W] = i_data[k*LANE_W +: LANE_W];
            end else begin
                pix[k*LANE_W +: LANE_W] = '0;
            end
            pair_sum[k*SUM_W +: SUM_W] = SUM_W'(r_held[k*LANE_W +: LANE_W])
                                       + SUM_W'(pix[k*LANE_W +: LANE_W]);
            pix_wide[k*SUM_W +: SUM_W] = SUM_W'(pix[k*LANE_W +: LANE_W]);
        end
    end

    assign col13       = DIM_W'(r_col);
    assign row13       = DIM_W'(r_row);
    assign w_even      = {i_cfg.width[DIM_W-1:1], 1'b0};
    assign h_even      = {i_cfg.height[DIM_W-1:1], 1'b0};
    assign col_half_nx = CNT_W'(r_col[CNT_W-1:1]) + CNT_W'(1);
    assign row_half_nx = CNT_W'(r_row[CNT_W-1:1]) + CNT_W'(1);
    assign half_rend   = (col_half_nx == i_cfg.width[DIM_W-1:1]);
    assign half_fend   = (row_half_nx == i_cfg.height[DIM_W-1:1]);

    always_comb begin
        emit           = 1'b0;
        n_held         = r_held;
        o_op.kind      = K_STORE;
        o_op.idx       = ROW_AW'(r_col);
        o_op.sum       = pair_sum;
        o_op.row_end   = 1'b0;
        o_op.frame_end = 1'b0;
        unique case (i_cfg.halve_mode)
            MODE_BOTH: begin
                if (col13 < w_even && row13 < h_even) begin
                    if (!r_col[0]) begin
                        n_held = pix;
                    end else begin
                        emit     = 1'b1;
                        o_op.idx = ROW_AW'(r_col[CNT_W-1:1]);
                        if (r_row[0]) begin
                            o_op.kind      = K_BOX;
                            o_op.row_end   = half_rend;
                            o_op.frame_end = half_rend && half_fend;
                        end
                    end
                end
            end
            MODE_HORIZ: begin
                if (col13 < w_even) begin
                    if (!r_col[0]) begin
                        n_held = pix;
                    end else begin
                        emit           = 1'b1;
                        o_op.kind      = K_PAIR;
                        o_op.row_end   = half_rend;
                        o_op.frame_end = half_rend && (row13 + DIM_W'(1) == i_cfg.height);
                    end
                end
            end
            MODE_VERT: begin
                if (row13 < h_even) begin
                    emit     = 1'b1;
                    o_op.sum = pix_wide;
                    if (r_row[0]) begin
                        o_op.kind      = K_VERT;
                        o_op.row_end   = (col13 + DIM_W'(1) == i_cfg.width);
                        o_op.frame_end = o_op.row_end && half_fend;
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign o_push = accept && cfg_ok && emit;

    // raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (accept && cfg_ok) begin
            if (col13 + DIM_W'(1) >= i_cfg.width) begin
                n_col = '0;
                if (row13 + DIM_W'(1) >= i_cfg.height) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + CNT_W'(1);
                end
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept && cfg_ok) r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ihbf_queue.sv =====
`default_nettype none

module ihbf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ihbf_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ihbf_pkg::t_op o_op
);
    import ihbf_pkg::*;

    t_op              r_slot [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QAW:0]     r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + QAW'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + QAW'(1);
            if (do_push && !do_pop) begin
                r_count <= r_count + (QAW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QAW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wr_ptr] <= i_op;
    end

endmodule

`default_nettype wire

// ===== rtl/ihbf_back.sv =====
`default_nettype none

module ihbf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  ihbf_pkg::t_op              i_q_op,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ihbf_pkg::PIX_W-1:0] o_data,
    output logic                       o_row_end,
    output logic                       o_frame_end
);
    import ihbf_pkg::*;

    // row store: pair sums or even-row pixels
    logic [ROW_W-1:0] r_row_mem [MAX_WIDTH];
    logic [ROW_W-1:0] r_rd;
    t_op              r_s1;
    logic             r_s1_valid;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_data;
    logic             r_out_rend;
    logic             r_out_fend;

    logic             s2_can;
    logic             s1_can;
    logic [PIX_W-1:0] n_data;
    logic [SUM_W-1:0] m_lane, s_lane;
    logic [SUM_W:0]   tot;

    assign s2_can = !r_out_valid || i_ready;
    assign s1_can = !r_s1_valid || s2_can;
    assign o_pop  = i_q_valid && s1_can;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_q_op.kind == K_STORE) r_row_mem[i_q_op.idx] <= i_q_op.sum;
            r_rd <= r_row_mem[i_q_op.idx];
            r_s1 <= i_q_op;
        end
    end

    always_comb begin
        n_data = '0;
        m_lane = '0;
        s_lane = '0;
        tot    = '0;
        for (int k = 0; k < LANES; k++) begin
            m_lane = r_rd[k*SUM_W +: SUM_W];
            s_lane = r_s1.sum[k*SUM_W +: SUM_W];
            tot    = (SUM_W+1)'(m_lane) + (SUM_W+1)'(s_lane);
            unique case (r_s1.kind)
                K_BOX:   n_data[k*LANE_W +: LANE_W] = tot[SUM_W:2];
                K_VERT:  n_data[k*LANE_W +: LANE_W] = tot[SUM_W-1:1];
                K_PAIR:  n_data[k*LANE_W +: LANE_W] = s_lane[SUM_W-1:1];
                K_STORE: n_data[k*LANE_W +: LANE_W] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_q_op.kind != K_STORE) begin
                r_s1_valid <= 1'b1;
            end else if (s2_can) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_can) r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_can && r_s1_valid) begin
            r_out_data <= n_data;
            r_out_rend <= r_s1.row_end;
            r_out_fend <= r_s1.frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_data      = r_out_data;
    assign o_row_end   = r_out_rend;
    assign o_frame_end = r_out_fend;

endmodule

`default_nettype wire

// ===== rtl/ihbf_checker.sv =====
`default_nettype none

module ihbf_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [31:0] o_m_tdata,
    input wire        o_m_tlast,
    input wire [0:0]  o_m_tuser,
    input wire        pready
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("output word changed while stalled");

    a_frame_is_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast)
        else $error("frame end without row end");

    a_quiet_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("config port not ready");

endmodule

bind image_halve_box_filter_top ihbf_checker u_ihbf_checker (.*);

`default_nettype wire
